/* sv/bmpd_pkg.sv */
// Shared types, codes and constants of the bitmap stream decoder.
package bmpd_pkg;

  localparam int unsigned DEFAULT_MAX_DIMENSION = 4096;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned TOK_DIM_W = 16;

  // Result kinds.
  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_MAGIC       = 3'd1;
  localparam logic [2:0] ERR_VERSION     = 3'd2;
  localparam logic [2:0] ERR_HEADER      = 3'd3;
  localparam logic [2:0] ERR_BPP         = 3'd4;
  localparam logic [2:0] ERR_COMPRESSED  = 3'd5;
  localparam logic [2:0] ERR_SIZE        = 3'd6;
  localparam logic [2:0] ERR_OFFSET      = 3'd7;

  // File byte positions at which header fields are taken and checked.
  localparam logic [31:0] POS_MAGIC_FIRST  = 32'd0;
  localparam logic [31:0] POS_MAGIC_SECOND = 32'd1;
  localparam logic [31:0] POS_OFFSET_END   = 32'd13;
  localparam logic [31:0] POS_HLEN_END     = 32'd17;
  localparam logic [31:0] POS_INFO_WIDTH   = 32'd21;
  localparam logic [31:0] POS_INFO_HEIGHT  = 32'd25;
  localparam logic [31:0] POS_INFO_BPP     = 32'd29;
  localparam logic [31:0] POS_INFO_COMP    = 32'd31;
  localparam logic [31:0] POS_CORE_WIDTH   = 32'd19;
  localparam logic [31:0] POS_CORE_HEIGHT  = 32'd21;
  localparam logic [31:0] POS_CORE_BPP     = 32'd25;

  // Header bytes already consumed when the header result is given.
  localparam logic [31:0] INFO_CONSUMED = 32'd32;
  localparam logic [31:0] CORE_CONSUMED = 32'd26;

  localparam logic [7:0]  MAGIC_B   = 8'h42;
  localparam logic [7:0]  MAGIC_M   = 8'h4D;
  localparam logic [31:0] HLEN_INFO = 32'd40;
  localparam logic [31:0] HLEN_CORE = 32'd12;
  localparam logic [31:0] HLEN_V3   = 32'd64;
  localparam logic [31:0] HLEN_V4   = 32'd108;
  localparam logic [31:0] HLEN_V5   = 32'd124;
  localparam logic [15:0] BPP_24    = 16'd24;
  localparam logic [15:0] HALF_NEG  = 16'h8000;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEAD,
    PH_DATA
  } phase_t;

  typedef enum logic [1:0] {
    TK_BYTE,
    TK_HDR,
    TK_ERR
  } tok_kind_t;

  // Work item passed from the parser to the pixel assembler.
  typedef struct packed {
    tok_kind_t            kind;
    logic [7:0]           data;
    logic [TOK_DIM_W-1:0] width;
    logic [TOK_DIM_W-1:0] height;
    logic [2:0]           err;
  } tok_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] column;
    logic [11:0] row;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [2:0]  error_code;
    logic        last_pixel;
  } res_t;

endpackage

/* sv/bmpd_ifs.sv */
// Byte input channel and result output channel interfaces.
interface bmpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       file_start;

  modport source (output valid, byte_value, file_start, input ready);
  modport sink (input valid, byte_value, file_start, output ready);
endinterface

interface bmpd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [11:0] column;
  logic [11:0] row;
  logic [12:0] image_width;
  logic [12:0] image_height;
  logic [2:0]  error_code;
  logic        last_pixel;

  modport source (output valid, kind, red, green, blue, column, row, image_width,
                  image_height, error_code, last_pixel, input ready);
  modport sink (input valid, kind, red, green, blue, column, row, image_width,
                image_height, error_code, last_pixel, output ready);
endinterface

/* sv/bmpd_front.sv */
// Header parser: tracks file position, checks header fields, classifies bytes.
module bmpd_front import bmpd_pkg::*; #(
  parameter int unsigned MAX_DIMENSION = DEFAULT_MAX_DIMENSION
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] in_byte,
  input  logic       in_file_start,
  output logic       tok_push,
  output tok_t       tok
);

  localparam logic [31:0] MAX_DIM = 32'(MAX_DIMENSION);

  phase_t               phase_r, phase_nxt, phase_eff;
  logic [31:0]          pos_r, pos_nxt, pos_eff;
  logic [31:0]          fa_r, fa_nxt, fa_prev, fa_new;
  logic [31:0]          offset_r, offset_nxt;
  logic                 is40_r, is40_nxt;
  logic [7:0]           first_r, first_nxt;
  logic [TOK_DIM_W-1:0] width_r, width_nxt, height_r, height_nxt;
  logic [15:0]          half;
  logic                 err;
  logic [2:0]           err_code;
  logic                 hdr_go;
  logic [31:0]          consumed;
  logic                 fa_ok, half_ok;

  always_comb begin
    phase_eff = in_file_start ? PH_HEAD : phase_r;
    pos_eff   = in_file_start ? '0 : pos_r;
    fa_prev   = in_file_start ? '0 : fa_r;
    fa_new    = {in_byte, fa_prev[31:8]};
    half      = fa_new[31:16];
    fa_ok     = (fa_new != '0) && (fa_new <= MAX_DIM);
    half_ok   = (half < HALF_NEG) && (half != '0) && ({16'd0, half} <= MAX_DIM);

    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    fa_nxt     = fa_r;
    offset_nxt = offset_r;
    is40_nxt   = is40_r;
    first_nxt  = first_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    err        = 1'b0;
    err_code   = ERR_NONE;
    hdr_go     = 1'b0;
    consumed   = INFO_CONSUMED;
    tok_push   = 1'b0;
    tok        = '{kind: TK_BYTE, data: in_byte, width: '0, height: '0, err: ERR_NONE};

    if (in_fire && (phase_eff != PH_IDLE)) begin
      phase_nxt = phase_eff;
      fa_nxt    = fa_new;
      pos_nxt   = (&pos_eff) ? pos_eff : pos_eff + 32'd1;
      if (phase_eff == PH_DATA) begin
        tok_push = (pos_eff >= offset_r);
      end else begin
        unique case (pos_eff)
          POS_MAGIC_FIRST: begin
            first_nxt = in_byte;
          end
          POS_MAGIC_SECOND: begin
            if ((first_r != MAGIC_B) || (in_byte != MAGIC_M)) begin
              err = 1'b1; err_code = ERR_MAGIC;
            end
          end
          POS_OFFSET_END: begin
            offset_nxt = fa_new;
          end
          POS_HLEN_END: begin
            is40_nxt = (fa_new == HLEN_INFO);
            if ((fa_new == HLEN_V3) || (fa_new == HLEN_V4) || (fa_new == HLEN_V5)) begin
              err = 1'b1; err_code = ERR_VERSION;
            end else if ((fa_new != HLEN_INFO) && (fa_new != HLEN_CORE)) begin
              err = 1'b1; err_code = ERR_HEADER;
            end
          end
          default: begin
            if (is40_r) begin
              unique case (pos_eff)
                POS_INFO_WIDTH: begin
                  if (!fa_ok) begin err = 1'b1; err_code = ERR_SIZE; end
                  width_nxt = fa_new[TOK_DIM_W-1:0];
                end
                POS_INFO_HEIGHT: begin
                  if (!fa_ok) begin err = 1'b1; err_code = ERR_SIZE; end
                  height_nxt = fa_new[TOK_DIM_W-1:0];
                end
                POS_INFO_BPP: begin
                  if (half != BPP_24) begin err = 1'b1; err_code = ERR_BPP; end
                end
                POS_INFO_COMP: begin
                  if (half != '0) begin
                    err = 1'b1; err_code = ERR_COMPRESSED;
                  end else begin
                    hdr_go = 1'b1; consumed = INFO_CONSUMED;
                  end
                end
                default: begin
                end
              endcase
            end else begin
              unique case (pos_eff)
                POS_CORE_WIDTH: begin
                  if (!half_ok) begin err = 1'b1; err_code = ERR_SIZE; end
                  width_nxt = half;
                end
                POS_CORE_HEIGHT: begin
                  if (!half_ok) begin err = 1'b1; err_code = ERR_SIZE; end
                  height_nxt = half;
                end
                POS_CORE_BPP: begin
                  if (half != BPP_24) begin
                    err = 1'b1; err_code = ERR_BPP;
                  end else begin
                    hdr_go = 1'b1; consumed = CORE_CONSUMED;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        endcase

        if (hdr_go) begin
          if (offset_r < consumed) begin
            err = 1'b1; err_code = ERR_OFFSET;
          end else begin
            tok_push   = 1'b1;
            tok.kind   = TK_HDR;
            tok.width  = width_r;
            tok.height = height_r;
            phase_nxt  = PH_DATA;
          end
        end
        if (err) begin
          tok_push  = 1'b1;
          tok.kind  = TK_ERR;
          tok.err   = err_code;
          phase_nxt = PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pos_r   <= '0;
      is40_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      is40_r  <= is40_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fa_r     <= fa_nxt;
    offset_r <= offset_nxt;
    first_r  <= first_nxt;
    width_r  <= width_nxt;
    height_r <= height_nxt;
  end

endmodule

/* sv/bmpd_queue.sv */
// Small register queue between the parser and the pixel assembler.
module bmpd_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      count_r <= count_r + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* sv/bmpd_back.sv */
// Pixel assembler: groups data bytes into pixels, drops row padding, drives results.
module bmpd_back import bmpd_pkg::*; #(
  parameter int unsigned MAX_DIMENSION = DEFAULT_MAX_DIMENSION
) (
  input  logic clk,
  input  logic rst_n,
  input  logic tok_valid,
  input  tok_t tok,
  output logic tok_pop,
  output logic out_valid,
  input  logic out_ready,
  output res_t res
);

  localparam int unsigned DIM_W = $clog2(MAX_DIMENSION + 1);

  logic             out_valid_r, out_valid_nxt;
  res_t             res_r, res_nxt;
  logic             active_r, active_nxt;
  logic [DIM_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [DIM_W-1:0] width_r, width_nxt, height_r, height_nxt;
  logic [DIM_W-1:0] col_inc, row_inc;
  logic [1:0]       pad_r, pad_nxt, chan_r, chan_nxt;
  logic [7:0]       b0_r, b0_nxt, b1_r, b1_nxt;
  logic [15:0]      col_ext, row_ext;
  logic             step, row_end;

  assign out_valid = out_valid_r;
  assign res       = res_r;

  always_comb begin
    step     = !out_valid_r || out_ready;
    tok_pop  = tok_valid && step;
    col_inc  = col_r + DIM_W'(1);
    row_inc  = row_r + DIM_W'(1);
    row_end  = (col_inc == width_r);
    col_ext  = 16'(col_r);
    row_ext  = 16'(row_r);

    out_valid_nxt = step ? 1'b0 : out_valid_r;
    res_nxt    = res_r;
    active_nxt = active_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    pad_nxt    = pad_r;
    chan_nxt   = chan_r;
    b0_nxt     = b0_r;
    b1_nxt     = b1_r;

    if (tok_pop) begin
      unique case (tok.kind)
        TK_HDR: begin
          res_nxt              = '0;
          res_nxt.kind         = KIND_HEADER;
          res_nxt.image_width  = tok.width[12:0];
          res_nxt.image_height = tok.height[12:0];
          out_valid_nxt = 1'b1;
          active_nxt = 1'b1;
          width_nxt  = tok.width[DIM_W-1:0];
          height_nxt = tok.height[DIM_W-1:0];
          col_nxt    = '0;
          row_nxt    = '0;
          pad_nxt    = '0;
          chan_nxt   = '0;
        end
        TK_ERR: begin
          res_nxt            = '0;
          res_nxt.kind       = KIND_ERROR;
          res_nxt.error_code = tok.err;
          out_valid_nxt = 1'b1;
          active_nxt = 1'b0;
        end
        TK_BYTE: begin
          if (active_r) begin
            if (pad_r != '0) begin
              pad_nxt = pad_r - 2'd1;
            end else if (chan_r == 2'd0) begin
              b0_nxt   = tok.data;
              chan_nxt = 2'd1;
            end else if (chan_r == 2'd1) begin
              b1_nxt   = tok.data;
              chan_nxt = 2'd2;
            end else begin
              chan_nxt           = 2'd0;
              res_nxt            = '0;
              res_nxt.kind       = KIND_PIXEL;
              res_nxt.red        = tok.data;
              res_nxt.green      = b1_r;
              res_nxt.blue       = b0_r;
              res_nxt.column     = col_ext[11:0];
              res_nxt.row        = row_ext[11:0];
              res_nxt.last_pixel = row_end && (row_inc == height_r);
              out_valid_nxt = 1'b1;
              if (row_end) begin
                col_nxt = '0;
                pad_nxt = width_r[1:0];
                row_nxt = row_inc;
                if (row_inc == height_r) begin
                  active_nxt = 1'b0;
                end
              end else begin
                col_nxt = col_inc;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      active_r    <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      pad_r       <= '0;
      chan_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      active_r    <= active_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      pad_r       <= pad_nxt;
      chan_r      <= chan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r    <= res_nxt;
    width_r  <= width_nxt;
    height_r <= height_nxt;
    b0_r     <= b0_nxt;
    b1_r     <= b1_nxt;
  end

endmodule

/* sv/bmp_rgb24_stream_decoder.sv */
// Top level of the streaming 24-bit bitmap decoder.
// The block takes a bitmap file one byte per transfer on in_ch; file_start
// marks the first byte of each file and restarts the parse at any time.
// Results leave on out_ch: one header result when the header passes its
// checks, then one pixel result per three data bytes (red, green, blue with
// the stored blue-first order undone, row padding dropped), or one error
// result after which bytes are ignored until the next file start.
// Throughput is one byte per cycle while the output does not stall: the
// parser classifies each byte as it is accepted and the pixel assembler
// retires one queued byte per cycle. An accepted byte's token enters the
// four-entry queue at the accepting edge, and the assembler takes it from
// there into the output register once that register is free.
// When the receiver stalls, the output register holds its result, the
// queue fills, and in_ch.ready falls once the queue is full; nothing is
// lost or repeated. Reset is synchronous and active low; afterwards the
// block is idle, the queue is empty and out_ch.valid is low.
module bmp_rgb24_stream_decoder import bmpd_pkg::*; #(
  parameter int unsigned MAX_DIMENSION = DEFAULT_MAX_DIMENSION
) (
  input  logic          clk,
  input  logic          rst_n,
  bmpd_byte_if.sink     in_ch,
  bmpd_result_if.source out_ch
);

  logic in_fire;
  logic q_full;
  logic tok_push, tok_valid, tok_pop;
  tok_t tok_in, tok_out;
  res_t res;

  // The queue has room for the token this byte may create.
  assign in_ch.ready = !q_full;
  assign in_fire     = in_ch.valid && !q_full;

  bmpd_front #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (in_fire),
    .in_byte       (in_ch.byte_value),
    .in_file_start (in_ch.file_start),
    .tok_push      (tok_push),
    .tok           (tok_in)
  );

  bmpd_queue #(
    .WIDTH ($bits(tok_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (tok_push),
    .push_data (tok_in),
    .full      (q_full),
    .pop       (tok_pop),
    .not_empty (tok_valid),
    .pop_data  (tok_out)
  );

  bmpd_back #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (tok_valid),
    .tok       (tok_out),
    .tok_pop   (tok_pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .res       (res)
  );

  assign out_ch.kind         = res.kind;
  assign out_ch.red          = res.red;
  assign out_ch.green        = res.green;
  assign out_ch.blue         = res.blue;
  assign out_ch.column       = res.column;
  assign out_ch.row          = res.row;
  assign out_ch.image_width  = res.image_width;
  assign out_ch.image_height = res.image_height;
  assign out_ch.error_code   = res.error_code;
  assign out_ch.last_pixel   = res.last_pixel;

endmodule
